/* rtl/core/ipv4_frt_pkg.sv */
package ipv4_frt_pkg;

  // fixed field widths
  localparam int unsigned AddrW   = 32;
  localparam int unsigned IdentW  = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned IhlW    = 4;
  localparam int unsigned FragOfsW = 13;
  localparam int unsigned AgeW    = 8;
  localparam int unsigned VerdW   = 3;

  // generation tag stored beside each coverage entry
  localparam int unsigned EpochW  = 8;
  localparam int unsigned EntryW  = 8;

  localparam logic [LenW:0] HeaderBytes = 17'd20;
  localparam logic [LenW-1:0] LenMax    = 16'hffff;

  // register map
  localparam logic [1:0] RegMaxAge = 2'd0;

  typedef enum logic [VerdW-1:0] {
    VERD_PENDING  = 3'd0,
    VERD_COMPLETE = 3'd1,
    VERD_MISMATCH = 3'd2,
    VERD_OVERFLOW = 3'd3,
    VERD_HOLES    = 3'd4
  } verdict_e;

  typedef enum logic [3:0] {
    S_WIPE,
    S_IDLE,
    S_CHECK,
    S_MARK_RD,
    S_MARK_WR,
    S_FIN,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

endpackage

/* rtl/core/ipv4_fragment_reassembly_tracker.sv */
// a tick acts at its accept edge, no result; a fragment goes to the check state (checked again
// after an open), then to the result state if the key or length check rejects it, else each map
// entry of its span is read then written, then the finish state, and once the last fragment is
// in, entries up to final_length/64 + 1 are read then checked; one request at a time, tready low
// until the result goes to the output register; reset: control state clears, max_age loads 15,
// then the map is wiped; the same wipe runs on every 256th open, when the epoch tag wraps
module ipv4_fragment_reassembly_tracker #(
  parameter int unsigned BUFFER_BYTES = 8192
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_addr[31:0], dst_addr[63:32], ident[79:64], total_length[95:80],
  // header_words[99:96], more_fragments[100], fragment_offset[113:101], zero pad
  input  logic [119:0] s_axis_tdata,
  // operation: 0 fragment header, 1 timer tick
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // verdict[2:0], write_offset[18:3], payload_length[34:19],
  // datagram_length[50:35], zero pad
  output logic [55:0]  m_axis_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned MapDepth = BUFFER_BYTES / 64 + 1;
  localparam int unsigned IdxW     = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int unsigned WordW    = ipv4_frt_pkg::EpochW + ipv4_frt_pkg::EntryW;
  localparam logic [16:0] BufLim   = 17'(BUFFER_BYTES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(MapDepth - 1);
  localparam logic [ipv4_frt_pkg::EpochW-1:0] EpochLast = '1;

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [7:0] max_age_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == ipv4_frt_pkg::RegMaxAge) ? {24'd0, max_age_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= 8'd15;
    end else if (cfg_wr && paddr == ipv4_frt_pkg::RegMaxAge) begin
      max_age_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // coverage map: tag + bitmap per entry, one read and one write port
  // an entry whose tag differs from the live epoch reads as empty
  // ---------------------------------------------------------------------------
  logic [WordW-1:0] map_mem [MapDepth];
  logic [WordW-1:0] map_rd_q;
  logic             map_re;
  logic [IdxW-1:0]  map_raddr;
  logic             map_we;
  logic [IdxW-1:0]  map_waddr;
  logic [WordW-1:0] map_wdata;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_re) begin
      map_rd_q <= map_mem[map_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  ipv4_frt_pkg::state_e state_q, state_d;
  logic                  wipe_ret_q, wipe_ret_d;   // wipe started by an open
  logic [ipv4_frt_pkg::EpochW-1:0] epoch_q, epoch_d;
  logic [IdxW-1:0]       ptr_q, ptr_d;

  logic [7:0]  age_q, age_d;
  logic [31:0] held_src_q, held_src_d;
  logic [31:0] held_dst_q, held_dst_d;
  logic [15:0] held_id_q, held_id_d;
  logic        last_seen_q, last_seen_d;
  logic [15:0] final_len_q, final_len_d;

  // captured request
  logic [31:0] f_src_q, f_dst_q;
  logic [15:0] f_id_q, f_tlen_q;
  logic [3:0]  f_ihl_q;
  logic        f_mf_q;
  logic [12:0] f_ofs_q;

  // marking span
  logic [IdxW-1:0] mark_first_q, mark_first_d;
  logic [IdxW-1:0] mark_last_q, mark_last_d;
  logic [IdxW-1:0] mark_hi_q, mark_hi_d;
  logic [2:0]      lo_bit_q, lo_bit_d;
  logic [2:0]      hi_bit_q, hi_bit_d;

  // result being built and result waiting on the output
  ipv4_frt_pkg::verdict_e res_verd_q, res_verd_d;
  logic [15:0] res_ofs_q, res_ofs_d;
  logic [15:0] res_plen_q, res_plen_d;
  logic [15:0] res_dlen_q, res_dlen_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_verd_q;
  logic [15:0] out_ofs_q, out_plen_q, out_dlen_q;
  logic        out_load;

  logic        in_acc;

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  logic [5:0]  hlen;
  logic [15:0] ofs_bytes;
  logic [15:0] plen;
  logic [16:0] end_bytes;
  logic [13:0] end_blk;
  logic [13:0] end_blk_m1;
  logic        key_miss;
  logic        len_short;
  logic        too_far;
  logic [7:0]  eff_entry;
  logic [2:0]  mask_lo;
  logic [3:0]  mask_hi;
  logic [7:0]  mark_mask;
  logic [9:0]  full_ent;
  logic [7:0]  want;
  logic [16:0] dlen_sum;

  assign hlen       = {f_ihl_q, 2'b00};
  assign ofs_bytes  = {f_ofs_q, 3'b000};
  assign plen       = f_tlen_q - {10'd0, hlen};
  assign end_bytes  = {1'b0, ofs_bytes} + {1'b0, plen};
  assign end_blk    = end_bytes[16:3];
  assign end_blk_m1 = end_blk - 14'd1;
  assign key_miss   = (held_src_q != f_src_q) || (held_dst_q != f_dst_q)
                      || (held_id_q != f_id_q);
  assign len_short  = f_tlen_q < {10'd0, hlen};
  assign too_far    = ({1'b0, ofs_bytes} > BufLim) || (end_bytes > BufLim);

  assign eff_entry = (map_rd_q[WordW-1 -: ipv4_frt_pkg::EpochW] == epoch_q)
                     ? map_rd_q[ipv4_frt_pkg::EntryW-1:0] : 8'd0;

  // blocks [lo, hi) of this entry, msb first
  assign mask_lo   = (ptr_q == mark_first_q) ? lo_bit_q : 3'd0;
  assign mask_hi   = (ptr_q == mark_hi_q) ? {1'b0, hi_bit_q} : 4'd8;
  assign mark_mask = (8'hff >> mask_lo) & ~(8'hff >> mask_hi);

  assign full_ent  = final_len_q[15:6];
  assign want      = ~(8'hff >> final_len_q[5:3]);
  assign dlen_sum  = {1'b0, final_len_q} + ipv4_frt_pkg::HeaderBytes;

  assign s_axis_tready = (state_q == ipv4_frt_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    wipe_ret_d   = wipe_ret_q;
    epoch_d      = epoch_q;
    ptr_d        = ptr_q;
    age_d        = age_q;
    held_src_d   = held_src_q;
    held_dst_d   = held_dst_q;
    held_id_d    = held_id_q;
    last_seen_d  = last_seen_q;
    final_len_d  = final_len_q;
    mark_first_d = mark_first_q;
    mark_last_d  = mark_last_q;
    mark_hi_d    = mark_hi_q;
    lo_bit_d     = lo_bit_q;
    hi_bit_d     = hi_bit_q;
    res_verd_d   = res_verd_q;
    res_ofs_d    = res_ofs_q;
    res_plen_d   = res_plen_q;
    res_dlen_d   = res_dlen_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    map_re       = 1'b0;
    map_raddr    = ptr_q;
    map_we       = 1'b0;
    map_waddr    = ptr_q;
    map_wdata    = {epoch_q, eff_entry | mark_mask};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ipv4_frt_pkg::S_WIPE: begin
        map_we    = 1'b1;
        map_wdata = '0;
        if (ptr_q == IdxLast) begin
          ptr_d   = '0;
          state_d = wipe_ret_q ? ipv4_frt_pkg::S_CHECK : ipv4_frt_pkg::S_IDLE;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end

      ipv4_frt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            // timer tick
            if (age_q != 8'd0) begin
              age_d = age_q - 8'd1;
            end
          end else begin
            state_d = ipv4_frt_pkg::S_CHECK;
          end
        end
      end

      ipv4_frt_pkg::S_CHECK: begin
        if (age_q == 8'd0) begin
          // open a new reassembly, then check again against the fresh key
          held_src_d  = f_src_q;
          held_dst_d  = f_dst_q;
          held_id_d   = f_id_q;
          age_d       = (max_age_q != 8'd0) ? max_age_q : 8'd1;
          last_seen_d = 1'b0;
          if (epoch_q == EpochLast) begin
            epoch_d    = '0;
            ptr_d      = '0;
            wipe_ret_d = 1'b1;
            state_d    = ipv4_frt_pkg::S_WIPE;
          end else begin
            epoch_d = epoch_q + ipv4_frt_pkg::EpochW'(1);
          end
        end else begin
          res_dlen_d = 16'd0;
          res_ofs_d  = ofs_bytes;
          res_plen_d = plen;
          if (key_miss) begin
            age_d      = 8'd0;
            res_ofs_d  = 16'd0;
            res_plen_d = 16'd0;
            res_verd_d = ipv4_frt_pkg::VERD_MISMATCH;
            state_d    = ipv4_frt_pkg::S_DONE;
          end else if (len_short) begin
            age_d      = 8'd0;
            res_plen_d = 16'd0;
            res_verd_d = ipv4_frt_pkg::VERD_OVERFLOW;
            state_d    = ipv4_frt_pkg::S_DONE;
          end else if (too_far) begin
            age_d      = 8'd0;
            res_verd_d = ipv4_frt_pkg::VERD_OVERFLOW;
            state_d    = ipv4_frt_pkg::S_DONE;
          end else begin
            if (!f_mf_q) begin
              last_seen_d = 1'b1;
              final_len_d = end_bytes[15:0];
            end
            mark_first_d = IdxW'(f_ofs_q[12:3]);
            mark_last_d  = IdxW'(end_blk_m1[13:3]);
            mark_hi_d    = IdxW'(end_blk[13:3]);
            lo_bit_d     = f_ofs_q[2:0];
            hi_bit_d     = end_blk[2:0];
            ptr_d        = IdxW'(f_ofs_q[12:3]);
            if ({1'b0, f_ofs_q} < end_blk) begin
              state_d = ipv4_frt_pkg::S_MARK_RD;
            end else begin
              state_d = ipv4_frt_pkg::S_FIN;
            end
          end
        end
      end

      ipv4_frt_pkg::S_MARK_RD: begin
        map_re  = 1'b1;
        state_d = ipv4_frt_pkg::S_MARK_WR;
      end

      ipv4_frt_pkg::S_MARK_WR: begin
        map_we = 1'b1;
        if (ptr_q == mark_last_q) begin
          state_d = ipv4_frt_pkg::S_FIN;
        end else begin
          ptr_d   = ptr_q + IdxW'(1);
          state_d = ipv4_frt_pkg::S_MARK_RD;
        end
      end

      ipv4_frt_pkg::S_FIN: begin
        ptr_d = '0;
        if (!last_seen_q) begin
          res_verd_d = ipv4_frt_pkg::VERD_PENDING;
          state_d    = ipv4_frt_pkg::S_DONE;
        end else if (32'(full_ent) >= MapDepth) begin
          age_d      = 8'd0;
          res_verd_d = ipv4_frt_pkg::VERD_HOLES;
          state_d    = ipv4_frt_pkg::S_DONE;
        end else begin
          state_d = ipv4_frt_pkg::S_SCAN_RD;
        end
      end

      ipv4_frt_pkg::S_SCAN_RD: begin
        map_re  = 1'b1;
        state_d = ipv4_frt_pkg::S_SCAN_CHK;
      end

      ipv4_frt_pkg::S_SCAN_CHK: begin
        if (ptr_q == IdxW'(full_ent)) begin
          age_d   = 8'd0;
          state_d = ipv4_frt_pkg::S_DONE;
          if (eff_entry == want) begin
            res_verd_d  = ipv4_frt_pkg::VERD_COMPLETE;
            res_dlen_d  = dlen_sum[16] ? ipv4_frt_pkg::LenMax : dlen_sum[15:0];
            final_len_d = res_dlen_d;
          end else begin
            res_verd_d = ipv4_frt_pkg::VERD_HOLES;
          end
        end else if (eff_entry != 8'hff) begin
          age_d      = 8'd0;
          res_verd_d = ipv4_frt_pkg::VERD_HOLES;
          state_d    = ipv4_frt_pkg::S_DONE;
        end else begin
          ptr_d   = ptr_q + IdxW'(1);
          state_d = ipv4_frt_pkg::S_SCAN_RD;
        end
      end

      ipv4_frt_pkg::S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ipv4_frt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ipv4_frt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipv4_frt_pkg::S_WIPE;
      wipe_ret_q  <= 1'b0;
      epoch_q     <= '0;
      ptr_q       <= '0;
      age_q       <= 8'd0;
      held_src_q  <= 32'd0;
      held_dst_q  <= 32'd0;
      held_id_q   <= 16'd0;
      last_seen_q <= 1'b0;
      final_len_q <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wipe_ret_q  <= wipe_ret_d;
      epoch_q     <= epoch_d;
      ptr_q       <= ptr_d;
      age_q       <= age_d;
      held_src_q  <= held_src_d;
      held_dst_q  <= held_dst_d;
      held_id_q   <= held_id_d;
      last_seen_q <= last_seen_d;
      final_len_q <= final_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_src_q  <= s_axis_tdata[31:0];
      f_dst_q  <= s_axis_tdata[63:32];
      f_id_q   <= s_axis_tdata[79:64];
      f_tlen_q <= s_axis_tdata[95:80];
      f_ihl_q  <= s_axis_tdata[99:96];
      f_mf_q   <= s_axis_tdata[100];
      f_ofs_q  <= s_axis_tdata[113:101];
    end
    mark_first_q <= mark_first_d;
    mark_last_q  <= mark_last_d;
    mark_hi_q    <= mark_hi_d;
    lo_bit_q     <= lo_bit_d;
    hi_bit_q     <= hi_bit_d;
    res_verd_q   <= res_verd_d;
    res_ofs_q    <= res_ofs_d;
    res_plen_q   <= res_plen_d;
    res_dlen_q   <= res_dlen_d;
    if (out_load) begin
      out_verd_q <= res_verd_q;
      out_ofs_q  <= res_ofs_q;
      out_plen_q <= res_plen_q;
      out_dlen_q <= res_dlen_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_dlen_q, out_plen_q, out_ofs_q, out_verd_q};

`ifndef NO_ASSERTIONS
  // a result only appears when the sequencer hands one over
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ipv4_frt_pkg::S_DONE))
    else $error("result appeared without a finished request");

  // every final verdict closes the reassembly
  a_close_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_verd_q != ipv4_frt_pkg::VERD_PENDING) |-> age_q == 8'd0)
    else $error("reassembly still open after a final verdict");

  // marking never runs past the last entry of the fragment span
  a_mark_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipv4_frt_pkg::S_MARK_WR |-> ptr_q <= mark_last_q)
    else $error("coverage marking ran past the fragment span");

  // no request is taken while the map is being wiped
  a_wipe_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipv4_frt_pkg::S_WIPE |=> !$past(s_axis_tready))
    else $error("request taken during map wipe");
`endif

endmodule
